// ----- hdl/swtx_pkg.sv -----
// ---------------------------------------------------------------------------
// swtx_pkg
// Shared constants, codes and types of the stop-and-wait transmit controller.
// ---------------------------------------------------------------------------
package swtx_pkg;

    // queue geometry and field widths
    localparam int QUEUE_DEPTH = 256;
    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TAG_W       = 16;
    localparam int LEN_W       = 8;
    localparam int MODE_W      = 2;
    localparam int STATE_W     = 2;
    localparam int TIMEOUT_W   = 16;
    localparam int RETRY_W     = 8;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 4'd1;
    localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 16'd2000;
    localparam logic [RETRY_W-1:0]   RETRY_LIMIT_RST = 8'd10;

    // event kinds
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ENQUEUE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ACK     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NACK    = 2'd3;

    // controller states
    localparam logic [STATE_W-1:0] ST_READY = 2'd0;
    localparam logic [STATE_W-1:0] ST_WAIT  = 2'd1;
    localparam logic [STATE_W-1:0] ST_ACK   = 2'd2;
    localparam logic [STATE_W-1:0] ST_NACK  = 2'd3;

    // word widths on the stream ports
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 48;

    // one queue entry
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [TAG_W-1:0] tag;
    } entry_t;

    // queue memory access request
    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        entry_t            wr_entry;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
    } mem_req_t;

    // per-event result, less the frame fields read from memory
    typedef struct packed {
        logic               send_start;
        logic [OCC_W-1:0]   queue_count;
        logic [STATE_W-1:0] ctrl_state;
        logic [RETRY_W-1:0] retry_count;
        logic               queue_flushed;
        logic               enqueue_rejected;
    } step_res_t;

endpackage

// ----- hdl/swtx_queue_ram.sv -----
// ---------------------------------------------------------------------------
// swtx_queue_ram
// Frame queue store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module swtx_queue_ram (
    input  logic              aclk,
    input  swtx_pkg::mem_req_t req,
    output swtx_pkg::entry_t   rd_entry
);
    import swtx_pkg::*;

    entry_t mem_array [QUEUE_DEPTH];
    entry_t rd_entry_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_array[req.wr_addr] <= req.wr_entry;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_entry_reg <= mem_array[req.rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

// ----- hdl/swtx_ctrl.sv -----
// ---------------------------------------------------------------------------
// swtx_ctrl
// Controller state, queue pointers, settings and per-event update logic.
// ---------------------------------------------------------------------------
module swtx_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [swtx_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [swtx_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              step_en,
    input  logic [swtx_pkg::MODE_W-1:0]       step_mode,
    input  logic [swtx_pkg::TAG_W-1:0]        step_tag,
    input  logic [swtx_pkg::LEN_W-1:0]        step_len,
    output swtx_pkg::mem_req_t                mem_req,
    output swtx_pkg::step_res_t               step_res
);
    import swtx_pkg::*;

    logic [TIMEOUT_W-1:0] ack_timeout_reg, ack_timeout_next;
    logic [RETRY_W-1:0]   retry_limit_reg, retry_limit_next;
    logic [STATE_W-1:0]   ctrl_reg, ctrl_next;
    logic [TIMEOUT_W-1:0] wait_reg, wait_next;
    logic [RETRY_W-1:0]   retries_reg, retries_next;
    logic [SLOT_W-1:0]    rd_slot_reg, rd_slot_next;
    logic [SLOT_W-1:0]    wr_slot_reg, wr_slot_next;
    logic [OCC_W-1:0]     occ_reg, occ_next;

    logic [TIMEOUT_W-1:0] wait_inc;
    logic [RETRY_W-1:0]   retries_inc;
    logic [SLOT_W-1:0]    rd_slot_inc;
    logic [SLOT_W-1:0]    wr_slot_inc;
    logic                 queue_full;
    logic                 queue_empty;

    // settings
    always_comb begin
        ack_timeout_next = ack_timeout_reg;
        retry_limit_next = retry_limit_reg;
        if (cfg_we) begin
            case (cfg_idx)
                REG_ACK_TIMEOUT: ack_timeout_next = cfg_wdata[TIMEOUT_W-1:0];
                REG_RETRY_LIMIT: retry_limit_next = cfg_wdata[RETRY_W-1:0];
                default: ;
            endcase
        end
    end

    // saturating and wrapping helpers
    assign wait_inc    = (wait_reg == {TIMEOUT_W{1'b1}}) ? wait_reg
                                                         : wait_reg + 1'b1;
    assign retries_inc = (retries_reg == {RETRY_W{1'b1}}) ? retries_reg
                                                          : retries_reg + 1'b1;
    assign rd_slot_inc = (rd_slot_reg == SLOT_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_slot_reg + 1'b1;
    assign wr_slot_inc = (wr_slot_reg == SLOT_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_slot_reg + 1'b1;
    assign queue_full  = (occ_reg == OCC_W'(QUEUE_DEPTH));
    assign queue_empty = (occ_reg == '0);

    // event update
    always_comb begin
        ctrl_next    = ctrl_reg;
        wait_next    = wait_reg;
        retries_next = retries_reg;
        rd_slot_next = rd_slot_reg;
        wr_slot_next = wr_slot_reg;
        occ_next     = occ_reg;

        mem_req.wr_en        = 1'b0;
        mem_req.wr_addr      = wr_slot_reg;
        mem_req.wr_entry.tag = step_tag;
        mem_req.wr_entry.len = step_len;
        mem_req.rd_en        = 1'b0;
        mem_req.rd_addr      = rd_slot_reg;

        step_res.send_start       = 1'b0;
        step_res.queue_flushed    = 1'b0;
        step_res.enqueue_rejected = 1'b0;

        case (step_mode)
            MODE_ENQUEUE: begin
                if (!queue_full) begin
                    mem_req.wr_en = step_en;
                    wr_slot_next  = wr_slot_inc;
                    occ_next      = occ_reg + 1'b1;
                end else begin
                    step_res.enqueue_rejected = 1'b1;
                end
            end
            MODE_ACK:  ctrl_next = ST_ACK;
            MODE_NACK: ctrl_next = ST_NACK;
            default: begin
                // tick: act on the recorded state
                case (ctrl_reg)
                    ST_ACK: begin
                        if (!queue_empty) begin
                            rd_slot_next = rd_slot_inc;
                            occ_next     = occ_reg - 1'b1;
                        end
                        ctrl_next = ST_READY;
                    end
                    ST_NACK: begin
                        retries_next = retries_inc;
                        ctrl_next    = ST_READY;
                    end
                    ST_WAIT: begin
                        wait_next = wait_inc;
                        if (wait_inc >= ack_timeout_reg) begin
                            wait_next    = '0;
                            retries_next = retries_inc;
                            ctrl_next    = ST_READY;
                        end
                    end
                    default: begin
                        if (!queue_empty) begin
                            ctrl_next           = ST_WAIT;
                            wait_next           = '0;
                            step_res.send_start = 1'b1;
                            mem_req.rd_en       = step_en;
                        end
                    end
                endcase
                // retry limit reached: drop the whole queue
                if (retries_next >= retry_limit_reg) begin
                    rd_slot_next           = '0;
                    wr_slot_next           = '0;
                    occ_next               = '0;
                    retries_next           = '0;
                    ctrl_next              = ST_READY;
                    step_res.queue_flushed = 1'b1;
                end
            end
        endcase

        step_res.queue_count = occ_next;
        step_res.ctrl_state  = ctrl_next;
        step_res.retry_count = retries_next;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_timeout_reg <= ACK_TIMEOUT_RST;
            retry_limit_reg <= RETRY_LIMIT_RST;
            ctrl_reg        <= ST_READY;
            wait_reg        <= '0;
            retries_reg     <= '0;
            rd_slot_reg     <= '0;
            wr_slot_reg     <= '0;
            occ_reg         <= '0;
        end else begin
            ack_timeout_reg <= ack_timeout_next;
            retry_limit_reg <= retry_limit_next;
            if (step_en) begin
                ctrl_reg    <= ctrl_next;
                wait_reg    <= wait_next;
                retries_reg <= retries_next;
                rd_slot_reg <= rd_slot_next;
                wr_slot_reg <= wr_slot_next;
                occ_reg     <= occ_next;
            end
        end
    end

endmodule

// ----- hdl/stop_and_wait_tx_controller_unit.sv -----
// ---------------------------------------------------------------------------
// stop_and_wait_tx_controller_unit
// Stop-and-wait transmit controller with a frame queue held in block memory.
// ---------------------------------------------------------------------------
// A result word passes the pending result register (with the queue memory read data)
// and then the output register. Throughput: one event per cycle unless the result
// side stalls; the memory read port is used at most once per event.
// Reset: synchronous, active low; queue emptied, state ready, counters zero,
// ack_timeout 2000 and retry_limit 10. Queue memory contents are not cleared.
module stop_and_wait_tx_controller_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swtx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [swtx_pkg::CFG_DATA_W-1:0]   cfg_data,
    // event stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [swtx_pkg::S_DATA_W-1:0]     s_axis_tdata,  // buffer_tag[15:0], frame_len[23:16]
    input  logic [swtx_pkg::MODE_W-1:0]       s_axis_tuser,  // mode[1:0]
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [swtx_pkg::M_DATA_W-1:0]     m_axis_tdata   // send_start[0], send_tag[16:1],
                                                             // send_len[24:17], queue_count[33:25],
                                                             // ctrl_state[35:34], retry_count[43:36],
                                                             // queue_flushed[44],
                                                             // enqueue_rejected[45], zeros above
);
    import swtx_pkg::*;

    mem_req_t  mem_req;
    entry_t    rd_entry;
    step_res_t step_res;

    logic      s_accept;
    logic      out_load;

    logic      pend_valid_reg, pend_valid_next;
    step_res_t pend_res_reg;
    logic      out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [TAG_W-1:0]    send_tag;
    logic [LEN_W-1:0]    send_len;

    // handshakes
    assign cfg_ready     = 1'b1;
    assign out_load      = pend_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !pend_valid_reg || out_load;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    swtx_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .step_en   (s_accept),
        .step_mode (s_axis_tuser),
        .step_tag  (s_axis_tdata[TAG_W-1:0]),
        .step_len  (s_axis_tdata[TAG_W +: LEN_W]),
        .mem_req   (mem_req),
        .step_res  (step_res)
    );

    swtx_queue_ram u_queue_ram (
        .aclk     (aclk),
        .req      (mem_req),
        .rd_entry (rd_entry)
    );

    // frame fields only shown on a send start
    assign send_tag = pend_res_reg.send_start ? rd_entry.tag : '0;
    assign send_len = pend_res_reg.send_start ? rd_entry.len : '0;

    // pending and output valid flags
    always_comb begin
        pend_valid_next = pend_valid_reg;
        if (out_load) begin
            pend_valid_next = 1'b0;
        end
        if (s_accept) begin
            pend_valid_next = 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        if (out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pend_res_reg <= step_res;
        end
        if (out_load) begin
            out_data_reg <= {2'b00,
                             pend_res_reg.enqueue_rejected,
                             pend_res_reg.queue_flushed,
                             pend_res_reg.retry_count,
                             pend_res_reg.ctrl_state,
                             pend_res_reg.queue_count,
                             send_len,
                             send_tag,
                             pend_res_reg.send_start};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench of the stop-and-wait transmit controller. Event words are queued
// by a sequencing block and fed through a clocked driver. Every accepted event
// word runs through a behavioural copy of the controller, and the status word
// it yields is held until the monitor checks the matching output word field
// by field. Both stream sides idle in random bursts. The result side holds off
// once for a long stretch, so that the unit fills and stalls its input.
// Register settings are changed between phases while the unit is idle.
// ---------------------------------------------------------------------------
module tb_top;

    import swtx_pkg::*;

    // one event word as offered to the unit
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  len;
    } tx_event_t;

    // one status word as returned by the unit
    typedef struct packed {
        logic               send_start;
        logic [TAG_W-1:0]   send_tag;
        logic [LEN_W-1:0]   send_len;
        logic [OCC_W-1:0]   queue_count;
        logic [STATE_W-1:0] ctrl_state;
        logic [RETRY_W-1:0] retry_count;
        logic               queue_flushed;
        logic               enqueue_rejected;
    } tx_status_t;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;  // buffer_tag[15:0], frame_len[23:16]
    logic [MODE_W-1:0]     s_axis_tuser  = '0;  // mode[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;        // send_start[0], send_tag[16:1],
                                                // send_len[24:17], queue_count[33:25],
                                                // ctrl_state[35:34], retry_count[43:36],
                                                // queue_flushed[44], enqueue_rejected[45]

    // stimulus and checking stores
    tx_event_t  event_backlog[$];
    tx_status_t status_due[$];
    tx_event_t  event_on_bus;
    int         posted      = 0;
    int         fault_count = 0;
    int         idle_pct    = 20;
    bit         hold_req    = 1'b0;
    bit         hold_done   = 1'b0;
    int         hold_left   = 0;
    int         src_gap     = 0;
    int         sink_gap    = 0;
    int         quiet_cycles = 0;

    // behavioural copy of the controller
    logic [TIMEOUT_W-1:0] mdl_timeout = ACK_TIMEOUT_RST;
    logic [RETRY_W-1:0]   mdl_limit   = RETRY_LIMIT_RST;
    logic [STATE_W-1:0]   mdl_state   = ST_READY;
    logic [TIMEOUT_W-1:0] mdl_wait    = '0;
    logic [RETRY_W-1:0]   mdl_retries = '0;
    logic [SLOT_W-1:0]    mdl_rd      = '0;
    logic [SLOT_W-1:0]    mdl_wr      = '0;
    logic [OCC_W-1:0]     mdl_occ     = '0;
    entry_t               mdl_store[QUEUE_DEPTH];

    stop_and_wait_tx_controller_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // advance the controller copy by one event, return the status it yields
    function automatic tx_status_t next_tx_status(input tx_event_t ev);
        tx_status_t st;
        st = '0;
        case (ev.mode)
            MODE_ENQUEUE: begin
                if (mdl_occ < QUEUE_DEPTH) begin
                    mdl_store[mdl_wr] = '{len: ev.len, tag: ev.tag};
                    mdl_wr  = mdl_wr + 1'b1;  // depth is a power of two, slot wraps
                    mdl_occ = mdl_occ + 1'b1;
                end else begin
                    st.enqueue_rejected = 1'b1;
                end
            end
            MODE_ACK:  mdl_state = ST_ACK;
            MODE_NACK: mdl_state = ST_NACK;
            default: begin
                case (mdl_state)
                    ST_ACK: begin
                        // empty queue: nothing to pop
                        if (mdl_occ != 0) begin
                            mdl_rd  = mdl_rd + 1'b1;
                            mdl_occ = mdl_occ - 1'b1;
                        end
                        mdl_state = ST_READY;
                    end
                    ST_NACK: begin
                        if (mdl_retries != '1) mdl_retries = mdl_retries + 1'b1;
                        mdl_state = ST_READY;
                    end
                    ST_WAIT: begin
                        if (mdl_wait != '1) mdl_wait = mdl_wait + 1'b1;
                        if (mdl_wait >= mdl_timeout) begin
                            mdl_wait = '0;
                            if (mdl_retries != '1) mdl_retries = mdl_retries + 1'b1;
                            mdl_state = ST_READY;
                        end
                    end
                    default: begin
                        if (mdl_occ != 0) begin
                            mdl_state     = ST_WAIT;
                            mdl_wait      = '0;
                            st.send_start = 1'b1;
                            st.send_tag   = mdl_store[mdl_rd].tag;
                            st.send_len   = mdl_store[mdl_rd].len;
                        end
                    end
                endcase
                // retry limit reached: drop the whole queue
                if (mdl_retries >= mdl_limit) begin
                    mdl_rd           = '0;
                    mdl_wr           = '0;
                    mdl_occ          = '0;
                    mdl_retries      = '0;
                    mdl_state        = ST_READY;
                    st.queue_flushed = 1'b1;
                end
            end
        endcase
        st.queue_count = mdl_occ;
        st.ctrl_state  = mdl_state;
        st.retry_count = mdl_retries;
        return st;
    endfunction

    function automatic void check_field(input string label, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            fault_count++;
        end
    endfunction

    // event driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                status_due.push_back(next_tx_status(event_on_bus));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (event_backlog.size() != 0 && idle_pct > 0 &&
                             $urandom_range(0, 99) < idle_pct) begin
                    src_gap = $urandom_range(0, 8);
                    s_axis_tvalid <= 1'b0;
                end else if (event_backlog.size() != 0) begin
                    event_on_bus = event_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {event_on_bus.len, event_on_bus.tag};
                    s_axis_tuser  <= event_on_bus.mode;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // status monitor and result-side back-pressure
    always @(posedge aclk) begin
        tx_status_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (status_due.size() == 0) begin
                    $display("%0t ns: status word with none pending, expected none, actual %0h",
                             $time, m_axis_tdata);
                    fault_count++;
                end else begin
                    want = status_due.pop_front();
                    check_field("send_start", 32'(want.send_start), 32'(m_axis_tdata[0]));
                    check_field("send_tag", 32'(want.send_tag), 32'(m_axis_tdata[16:1]));
                    check_field("send_len", 32'(want.send_len), 32'(m_axis_tdata[24:17]));
                    check_field("queue_count", 32'(want.queue_count),
                                32'(m_axis_tdata[33:25]));
                    check_field("ctrl_state", 32'(want.ctrl_state), 32'(m_axis_tdata[35:34]));
                    check_field("retry_count", 32'(want.retry_count),
                                32'(m_axis_tdata[43:36]));
                    check_field("queue_flushed", 32'(want.queue_flushed),
                                32'(m_axis_tdata[44]));
                    check_field("enqueue_rejected", 32'(want.enqueue_rejected),
                                32'(m_axis_tdata[45]));
                end
            end
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                sink_gap = $urandom_range(0, 8);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog: too long without any word moving
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic post(input logic [MODE_W-1:0] mode, input logic [TAG_W-1:0] tag,
                        input logic [LEN_W-1:0] len);
        tx_event_t ev;
        ev.mode = mode;
        ev.tag  = tag;
        ev.len  = len;
        event_backlog.push_back(ev);
        posted++;
    endtask

    task automatic post_frame();
        post(MODE_ENQUEUE, TAG_W'($urandom_range(0, 65535)), LEN_W'($urandom_range(0, 255)));
    endtask

    // mostly well-formed send/acknowledge exchanges, some random noise
    task automatic post_traffic(input int count, input int ack_pct);
        int stop_at;
        int wait_max;
        int pick;
        stop_at = posted + count;
        while (posted < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                post(MODE_W'($urandom_range(0, 3)), TAG_W'($urandom_range(0, 65535)),
                     LEN_W'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(0, 2)) post_frame();
                post(MODE_TICK, '0, '0);
                wait_max = (mdl_timeout > 6) ? 6 : mdl_timeout;
                repeat ($urandom_range(0, wait_max + 1)) post(MODE_TICK, '0, '0);
                pick = $urandom_range(0, 99);
                if (pick < ack_pct)
                    post(MODE_ACK, '0, '0);
                else if (pick < 95)
                    post(MODE_NACK, '0, '0);
                post(MODE_TICK, '0, '0);
            end
        end
    endtask

    // wait until every posted event has produced its status word
    task automatic drain();
        do @(posedge aclk);
        while (event_backlog.size() != 0 || s_axis_tvalid || status_due.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            REG_ACK_TIMEOUT: mdl_timeout = val[TIMEOUT_W-1:0];
            REG_RETRY_LIMIT: mdl_limit   = val[RETRY_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [TIMEOUT_W-1:0] timeout, input logic [RETRY_W-1:0] limit,
                             input int idle, input int count, input int fill,
                             input int ack_pct);
        drain();
        write_reg(REG_ACK_TIMEOUT, timeout);
        write_reg(REG_RETRY_LIMIT, CFG_DATA_W'(limit));
        idle_pct = idle;
        repeat (fill) post_frame();
        post_traffic(count - fill, ack_pct);
    endtask

    // test sequence
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed events on the reset settings
        post(MODE_TICK, '0, '0);             // idle tick, empty queue
        post(MODE_ACK, 16'hFFFF, 8'hFF);     // ack with empty queue, fields ignored
        post(MODE_TICK, 16'hFFFF, 8'hFF);
        post(MODE_NACK, '0, '0);             // nack while ready
        post(MODE_TICK, '0, '0);
        post(MODE_ENQUEUE, 16'h0000, 8'h00);
        post(MODE_ENQUEUE, 16'hFFFF, 8'hFF);
        post(MODE_ENQUEUE, 16'hAAAA, 8'h55);
        post(MODE_ENQUEUE, 16'h5555, 8'hAA);
        post(MODE_TICK, '0, '0);             // start sending head frame
        post(MODE_TICK, '0, '0);             // waiting
        post(MODE_NACK, '0, '0);
        post(MODE_TICK, '0, '0);             // retry counted
        post(MODE_TICK, '0, '0);             // resend
        post(MODE_ACK, '0, '0);
        post(MODE_TICK, '0, '0);             // pop
        post(MODE_TICK, '0, '0);
        post(MODE_ACK, '0, '0);
        post(MODE_TICK, '0, '0);
        post(MODE_ACK, '0, '0);              // ack while ready pops unsent head
        post(MODE_TICK, '0, '0);
        post(MODE_TICK, '0, '0);
        post(MODE_ACK, '0, '0);
        post(MODE_TICK, '0, '0);

        // register settings, extremes included
        run_phase(16'd1, 8'd1, 25, 290, 0, 60);
        run_phase(16'd0, 8'd0, 0, 290, 0, 60);
        hold_req = 1'b1;
        run_phase(16'd4, 8'd3, 30, 290, 260, 70);
        run_phase(16'hFFFF, 8'hFF, 15, 290, 200, 90);
        run_phase(16'd2, 8'd6, 40, 290, 0, 60);
        run_phase(16'd3, 8'd2, 0, 290, 0, 55);

        drain();
        repeat (10) @(posedge aclk);
        if (fault_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- stop_and_wait_tx_controller_unit.f -----
hdl/swtx_pkg.sv
hdl/swtx_queue_ram.sv
hdl/swtx_ctrl.sv
hdl/stop_and_wait_tx_controller_unit.sv
dv/tb_top.sv
